[hw/rtl/sha_pkg.sv]
`default_nettype none
package sha_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned INC_W  = 3;

	// padding word when the final word carries all four bytes
	localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;
	localparam logic [INC_W-1:0]  FULL_INC = 3'd4;

	// one queued word, already masked and padded when it closes a message
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [INC_W-1:0]  inc;
		logic              last;
		logic              full;
	} entry_t;

	localparam logic [WORD_W-1:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
			input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [WORD_W-1:0] sml_sig0(input logic [WORD_W-1:0] x);
		sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] sml_sig1(input logic [WORD_W-1:0] x);
		sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sha_front.sv]
`default_nettype none
module sha_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [34:0]     s_tdata,   // message_word[31:0], valid_bytes[34:32]
	input  wire logic            s_tlast,
	output logic                 enq_valid,
	input  wire logic            enq_ready,
	output sha_pkg::entry_t      enq_data
);

	logic            valid_s1;
	sha_pkg::entry_t entry_s1;
	sha_pkg::entry_t entry_d;
	logic [2:0]      vbs;
	logic [31:0]     w;

	assign w = s_tdata[31:0];

	always_comb begin
		// saturate the byte count; words that do not close a message count four bytes
		if (!s_tlast || s_tdata[34:32] > sha_pkg::FULL_INC) begin
			vbs = sha_pkg::FULL_INC;
		end else begin
			vbs = s_tdata[34:32];
		end
		entry_d.inc  = vbs;
		entry_d.last = s_tlast;
		entry_d.full = (vbs == sha_pkg::FULL_INC);
		case (vbs)
			3'd0:    entry_d.word = sha_pkg::PAD_WORD;
			3'd1:    entry_d.word = {w[31:24], 24'h80_0000};
			3'd2:    entry_d.word = {w[31:16], 16'h8000};
			3'd3:    entry_d.word = {w[31:8], 8'h80};
			default: entry_d.word = w;
		endcase
	end

	assign s_tready  = !valid_s1 || enq_ready;
	assign enq_valid = valid_s1;
	assign enq_data  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/sha_queue.sv]
`default_nettype none
module sha_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            enq_valid,
	output logic                 enq_ready,
	input  wire sha_pkg::entry_t enq_data,
	output logic                 deq_valid,
	input  wire logic            deq_ready,
	output sha_pkg::entry_t      deq_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sha_pkg::entry_t mem [DEPTH];
	sha_pkg::entry_t head_q;
	logic            head_v_q;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic            push, pop, load;

	assign enq_ready = (cnt_q != FULL_CNT);
	assign push      = enq_valid && enq_ready;
	assign pop       = head_v_q && deq_ready;
	assign load      = (cnt_q != '0) && (!head_v_q || pop);
	assign deq_valid = head_v_q;
	assign deq_data  = head_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= enq_data;
		end
		if (load) begin
			head_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			head_v_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(load);
			if (load) begin
				head_v_q <= 1'b1;
			end else if (pop) begin
				head_v_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

[hw/rtl/sha_back.sv]
`default_nettype none
module sha_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire sha_pkg::entry_t q_data,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata,   // digest_word[31:0]
	output logic                 m_tlast
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_COMP = 6'b000010,
		S_HADD = 6'b000100,
		S_PADW = 6'b001000,
		S_ZERO = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] kw_q;
	logic [31:0] pw_q;
	logic [3:0]  pos_q;
	logic [63:0] cnt_q;
	logic [6:0]  round_q;
	logic [2:0]  out_idx_q;
	logic        pad_q, pend_q, lenok_q;

	logic        w_wr_en, start_comp;
	logic [31:0] w_wr_data;
	logic [31:0] len_hi, len_lo;
	logic        sched_on, rnd_on;
	logic [31:0] w_new, t1, t2;

	assign len_hi = cnt_q[60:29];
	assign len_lo = {cnt_q[28:0], 3'b000};

	assign q_ready  = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = h_q[0];
	assign m_tlast  = (out_idx_q == 3'd7);

	always_comb begin
		w_wr_en    = 1'b0;
		w_wr_data  = q_data.word;
		start_comp = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				w_wr_en    = q_valid && (!q_data.last || q_data.full);
				start_comp = w_wr_en && (pos_q == 4'd15);
			end
			S_PADW: begin
				w_wr_en    = 1'b1;
				w_wr_data  = pw_q;
				start_comp = (pos_q == 4'd15);
			end
			S_ZERO: begin
				w_wr_en    = 1'b1;
				w_wr_data  = '0;
				if (lenok_q && pos_q == 4'd14) begin
					w_wr_data = len_hi;
				end else if (lenok_q && pos_q == 4'd15) begin
					w_wr_data = len_lo;
				end
				start_comp = (pos_q == 4'd15);
			end
			default: begin
				w_wr_en = 1'b0;
			end
		endcase
	end

	// schedule runs ahead of the compression rounds; each round's K+W is registered in kw_q before use
	assign sched_on = !round_q[6];
	assign rnd_on   = (round_q != 7'd0);

	always_comb begin
		if (round_q[6:4] == 3'd0) begin
			w_new = w_q[0];
		end else begin
			w_new = w_q[0] + sha_pkg::sml_sig0(w_q[1]) + w_q[9]
				+ sha_pkg::sml_sig1(w_q[14]);
		end
		t1 = v_q[7] + sha_pkg::big_sig1(v_q[4])
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kw_q;
		t2 = sha_pkg::big_sig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (w_wr_en) begin
			w_q[pos_q] <= w_wr_data;
		end
		if (state_q == S_IDLE && q_valid && q_data.last) begin
			pw_q <= q_data.full ? sha_pkg::PAD_WORD : q_data.word;
		end
		if (start_comp) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end
		if (state_q == S_COMP && sched_on) begin
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[15] <= w_new;
			kw_q    <= sha_pkg::ROUND_K[round_q[5:0]] + w_new;
		end
		if (state_q == S_COMP && rnd_on) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			round_q   <= '0;
			out_idx_q <= '0;
			pad_q     <= 1'b0;
			pend_q    <= 1'b0;
			lenok_q   <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::IV[i];
			end
		end else begin
			if (w_wr_en) begin
				pos_q <= pos_q + 4'd1;
			end
			if (start_comp) begin
				round_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cnt_q  <= cnt_q + 64'(q_data.inc);
						pend_q <= q_data.last;
						if (start_comp) begin
							state_q <= S_COMP;
						end else if (q_data.last) begin
							state_q <= S_PADW;
						end
					end
				end
				S_PADW: begin
					pad_q   <= 1'b1;
					lenok_q <= (pos_q < 4'd14);
					state_q <= start_comp ? S_COMP : S_ZERO;
				end
				S_ZERO: begin
					if (start_comp) begin
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'd64) begin
						state_q <= S_HADD;
					end
				end
				S_HADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (pad_q) begin
						if (lenok_q) begin
							state_q <= S_OUT;
						end else begin
							// length did not fit: fill a whole extra block
							lenok_q <= 1'b1;
							state_q <= S_ZERO;
						end
					end else if (pend_q) begin
						state_q <= S_PADW;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= sha_pkg::IV[i];
							end
							cnt_q   <= '0;
							pos_q   <= '0;
							pad_q   <= 1'b0;
							pend_q  <= 1'b0;
							lenok_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							for (int i = 0; i < 7; i++) begin
								h_q[i] <= h_q[i+1];
							end
							h_q[7] <= h_q[0];
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> h_q[0] == sha_pkg::IV[0] && cnt_q == 64'd0)
		else $error("state not restored after digest");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMP |-> !round_q[6] || round_q[5:0] == 6'd0)
		else $error("round counter overran");
	a_out_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> pos_q == 4'd0 && pad_q && lenok_q)
		else $error("digest emitted before padding finished");
`endif

endmodule
`default_nettype wire

[hw/rtl/sha256_stream_hasher.sv]
// A word passes the front register, queue memory and queue head register into the block buffer.
// Each full block runs the compression rounds (S_COMP) and then one hash add (S_HADD).
// Padding fills the rest of the final block at 1 word per cycle, then 1 or 2 more compressions.
// The single shared round unit takes no new words while it compresses, pads or sends a digest.
// The 8 digest words leave at 1 per cycle as the sink takes them.
// Reset (arst_n low, asynchronous): hash words to initial values, counts and queue cleared.
`default_nettype none
module sha256_stream_hasher #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // message_word[31:0], valid_bytes[34:32], zeros
	input  wire logic        s_tlast,   // last_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // digest_word[31:0]
	output logic             m_tlast    // last_digest_word
);

	logic            enq_valid, enq_ready;
	sha_pkg::entry_t enq_data;
	logic            deq_valid, deq_ready;
	sha_pkg::entry_t deq_data;

	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata[34:0]),
		.s_tlast   (s_tlast),
		.enq_valid (enq_valid),
		.enq_ready (enq_ready),
		.enq_data  (enq_data)
	);

	sha_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq_valid (enq_valid),
		.enq_ready (enq_ready),
		.enq_data  (enq_data),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_data  (deq_data)
	);

	sha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (deq_valid),
		.q_ready  (deq_ready),
		.q_data   (deq_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
